>>> rtl/core/bls_pkg.sv
`default_nettype none

package bls_pkg;

	// fixed field widths of the item ports
	localparam int IDX_W = 10;
	localparam int FLD_W = 24;
	localparam int LEN_W = 25;
	localparam int CNT_W = 13;

	// operation codes
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_MEASURE = 1'b1;

	// start, running and done of one serial arithmetic unit
	typedef struct packed {
		logic start;
	} unit_cmd_t;

	typedef struct packed {
		logic running;
		logic done;
	} unit_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/bls_node_mem.sv
`default_nettype none

module bls_node_mem #(
	parameter int DEPTH = 1024,
	parameter int WW    = 72
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WW-1:0]            wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WW-1:0]            rdata_q
);

	logic [WW-1:0] store_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= store_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bls_sqmul.sv
`default_nettype none

// Sum of squared coordinate differences, one multiplier bit per cycle on
// all three axes at once.
module bls_sqmul import bls_pkg::*; #(
	parameter int CW = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire unit_cmd_t           cmd,
	input  wire logic [3*CW-1:0]     a_pos,
	input  wire logic [3*CW-1:0]     b_pos,
	output unit_stat_t               stat,
	output logic      [2*CW+1:0]     sq_sum
);

	localparam int DW  = CW + 1;
	localparam int SQW = 2 * CW + 2;
	localparam int CTW = $clog2(DW + 1);

	logic [DW-1:0]  mplr_q [3];
	logic [SQW-1:0] mcnd_q [3];
	logic [SQW-1:0] acc_q;
	logic [CTW-1:0] cnt_q;
	logic           run_q;
	logic           done_q;
	logic [DW-1:0]  absd [3];
	logic [SQW-1:0] addsum;

	// absolute differences per axis
	always_comb begin
		logic signed [DW-1:0] df;
		for (int k = 0; k < 3; k++) begin
			df = DW'(signed'(a_pos[k*CW +: CW])) - DW'(signed'(b_pos[k*CW +: CW]));
			absd[k] = df[DW-1] ? DW'(-df) : DW'(df);
		end
	end

	// partial products selected by the current multiplier bits
	always_comb begin
		addsum = acc_q;
		for (int k = 0; k < 3; k++) begin
			if (mplr_q[k][0]) begin
				addsum = addsum + mcnd_q[k];
			end
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CTW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift and accumulate
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
			for (int k = 0; k < 3; k++) begin
				mplr_q[k] <= absd[k];
				mcnd_q[k] <= SQW'(absd[k]);
			end
		end else if (run_q) begin
			acc_q <= addsum;
			for (int k = 0; k < 3; k++) begin
				mplr_q[k] <= mplr_q[k] >> 1;
				mcnd_q[k] <= mcnd_q[k] << 1;
			end
		end
	end

	assign stat.running = run_q;
	assign stat.done    = done_q;
	assign sq_sum       = acc_q;

endmodule

`default_nettype wire

>>> rtl/core/bls_isqrt.sv
`default_nettype none

// Truncating integer square root, one root bit per cycle.
module bls_isqrt import bls_pkg::*; #(
	parameter int RW = 25
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire unit_cmd_t         cmd,
	input  wire logic [2*RW-1:0]   radicand,
	output unit_stat_t             stat,
	output logic      [RW-1:0]     root
);

	localparam int CTW = $clog2(RW + 1);

	logic [2*RW-1:0] rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [CTW-1:0]  cnt_q;
	logic            run_q;
	logic            done_q;
	logic [RW+2:0]   r2;
	logic [RW+2:0]   trial;
	logic            ge;

	// next two radicand bits against 4*root+1
	assign r2    = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (r2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CTW'(RW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below 2*root+1, so RW+1 bits hold it
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (RW+1)'(r2 - trial) : r2[RW:0];
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign stat.running = run_q;
	assign stat.done    = done_q;
	assign root         = root_q;

endmodule

`default_nettype wire

>>> rtl/core/bls_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module bls_div import bls_pkg::*; #(
	parameter int NW  = 38,
	parameter int DVW = 13
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire unit_cmd_t       cmd,
	input  wire logic [NW-1:0]   numer,
	input  wire logic [DVW-1:0]  denom,
	output unit_stat_t           stat,
	output logic      [NW-1:0]   quot
);

	localparam int CTW = $clog2(NW + 1);

	logic [NW-1:0]  quo_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] dvs_q;
	logic [CTW-1:0] cnt_q;
	logic           run_q;
	logic           done_q;
	logic [DVW:0]   t;
	logic           ge;

	assign t  = {rem_q, quo_q[NW-1]};
	assign ge = (t >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CTW'(NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator shifts out on top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= numer;
			rem_q <= '0;
			dvs_q <= denom;
		end else if (run_q) begin
			rem_q <= ge ? DVW'(t - {1'b0, dvs_q}) : t[DVW-1:0];
			quo_q <= (quo_q << 1) | NW'(ge);
		end
	end

	assign stat.running = run_q;
	assign stat.done    = done_q;
	assign quot         = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/bond_length_statistics_unit.sv
`default_nettype none

// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+-----------------------
// item in  | operation node_index coord_x/y/z end_a end_b       | start && !busy
//          | last_pair                                          |
// result   | min_length max_length mean_length bond_count       | done, one cycle
//
// A position write leaves busy low.
// A measure holds busy through two reads of the single node memory read port,
// the bit-serial square sum and the bit-serial square root.
// A measure marked last then runs the serial divider that forms the mean;
// done strobes in the first idle cycle after.
// Reset clears the control and the running statistics; node memory is not cleared.
// The receiver cannot stall results, so no output holding is needed.
module bond_length_statistics_unit import bls_pkg::*; #(
	parameter int MAX_NODES  = 1024,
	parameter int MAX_BONDS  = 4096,
	parameter int COORD_BITS = 24
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic                    operation,
	input  wire logic        [IDX_W-1:0] node_index,
	input  wire logic signed [FLD_W-1:0] coord_x,
	input  wire logic signed [FLD_W-1:0] coord_y,
	input  wire logic signed [FLD_W-1:0] coord_z,
	input  wire logic        [IDX_W-1:0] end_a,
	input  wire logic        [IDX_W-1:0] end_b,
	input  wire logic                    last_pair,
	output logic                         done,
	output logic             [LEN_W-1:0] min_length,
	output logic             [LEN_W-1:0] max_length,
	output logic             [LEN_W-1:0] mean_length,
	output logic             [CNT_W-1:0] bond_count
);

	localparam int CW  = COORD_BITS;
	localparam int DW  = CW + 1;
	localparam int SQW = 2 * CW + 2;
	localparam int CNW = $clog2(MAX_BONDS + 1);
	localparam int SW  = DW + CNW;
	localparam int AW  = $clog2(MAX_NODES);
	localparam int XW  = (AW > IDX_W) ? AW : IDX_W;
	localparam int IW  = (CW > FLD_W) ? CW : FLD_W;
	localparam int PW  = 3 * CW;
	localparam logic [31:0] NODES_U = 32'(MAX_NODES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDB  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_SQ   = 3'd3;
	localparam logic [2:0] ST_RT   = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_DST  = 3'd6;
	localparam logic [2:0] ST_DIV  = 3'd7;

	logic [2:0]     state_q;
	logic           va_q;
	logic           vb_q;
	logic           last_q;
	logic [AW-1:0]  addr_b_q;
	logic [PW-1:0]  pa_q;
	logic [PW-1:0]  pb;
	logic [DW-1:0]  min_q;
	logic [DW-1:0]  max_q;
	logic [SW-1:0]  sum_q;
	logic [CNW-1:0] cnt_q;
	logic           done_q;

	logic           accept;
	logic [XW-1:0]  ia;
	logic [XW-1:0]  ib;
	logic [XW-1:0]  iw;
	logic           wr_ok;
	logic [IW-1:0]  ex;
	logic [IW-1:0]  ey;
	logic [IW-1:0]  ez;
	logic           mem_we;
	logic           mem_re;
	logic [AW-1:0]  mem_raddr;
	logic [PW-1:0]  mem_rdata;

	unit_cmd_t      sq_cmd;
	unit_cmd_t      rt_cmd;
	unit_cmd_t      dv_cmd;
	unit_stat_t     sq_stat;
	unit_stat_t     rt_stat;
	unit_stat_t     dv_stat;
	logic [SQW-1:0] sq_res;
	logic [DW-1:0]  bond_len;
	logic [SW-1:0]  quo;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// index widening and range checks
	assign ia    = XW'(end_a);
	assign ib    = XW'(end_b);
	assign iw    = XW'(node_index);
	assign wr_ok = (32'(node_index) < NODES_U);

	// low COORD_BITS of each coordinate, sign taken from its top bit
	assign ex = IW'($unsigned(coord_x));
	assign ey = IW'($unsigned(coord_y));
	assign ez = IW'($unsigned(coord_z));

	assign mem_we    = accept && (operation == OP_WRITE) && wr_ok;
	assign mem_re    = (accept && (operation == OP_MEASURE)) || (state_q == ST_RDB);
	assign mem_raddr = (state_q == ST_RDB) ? addr_b_q : ia[AW-1:0];

	bls_node_mem #(
		.DEPTH(MAX_NODES),
		.WW   (PW)
	) u_mem (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (iw[AW-1:0]),
		.wdata  ({ez[CW-1:0], ey[CW-1:0], ex[CW-1:0]}),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata_q(mem_rdata)
	);

	// out-of-range ends sit at the origin
	assign pb = vb_q ? mem_rdata : '0;

	assign sq_cmd.start = (state_q == ST_LOAD);
	assign rt_cmd.start = (state_q == ST_SQ) && sq_stat.done;
	assign dv_cmd.start = (state_q == ST_DST);

	bls_sqmul #(
		.CW(CW)
	) u_sqmul (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (sq_cmd),
		.a_pos (pa_q),
		.b_pos (pb),
		.stat  (sq_stat),
		.sq_sum(sq_res)
	);

	bls_isqrt #(
		.RW(DW)
	) u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (rt_cmd),
		.radicand(sq_res),
		.stat    (rt_stat),
		.root    (bond_len)
	);

	bls_div #(
		.NW (SW),
		.DVW(CNW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (dv_cmd),
		.numer (sum_q),
		.denom (cnt_q),
		.stat  (dv_stat),
		.quot  (quo)
	);

	// sequencer and running statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			min_q   <= '1;
			max_q   <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && (operation == OP_MEASURE)) begin
						state_q <= ST_RDB;
					end
				end
				ST_RDB: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					if (sq_stat.done) begin
						state_q <= ST_RT;
					end
				end
				ST_RT: begin
					if (rt_stat.done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (cnt_q < CNW'(MAX_BONDS)) begin
						if (bond_len < min_q) begin
							min_q <= bond_len;
						end
						if (bond_len > max_q) begin
							max_q <= bond_len;
						end
						sum_q <= sum_q + SW'(bond_len);
						cnt_q <= cnt_q + 1'b1;
					end
					state_q <= last_q ? ST_DST : ST_IDLE;
				end
				ST_DST: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dv_stat.done) begin
						done_q  <= 1'b1;
						min_q   <= '1;
						max_q   <= '0;
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture and node fetch
	always_ff @(posedge clk) begin
		if (accept && (operation == OP_MEASURE)) begin
			va_q     <= (32'(end_a) < NODES_U);
			vb_q     <= (32'(end_b) < NODES_U);
			last_q   <= last_pair;
			addr_b_q <= ib[AW-1:0];
		end
		if (state_q == ST_RDB) begin
			pa_q <= va_q ? mem_rdata : '0;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV) && dv_stat.done) begin
			min_length  <= LEN_W'(min_q);
			max_length  <= LEN_W'(max_q);
			mean_length <= (cnt_q == '0) ? '0 : LEN_W'(quo);
			bond_count  <= CNT_W'(cnt_q);
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bls_pkg::*;

	localparam int NODE_COUNT = 1024;
	localparam int BOND_LIMIT = 4096;
	localparam int COORD_W    = 24;
	localparam int RANDOM_ITEMS = 530;

	typedef struct packed {
		logic                    operation;
		logic        [IDX_W-1:0] node_index;
		logic signed [FLD_W-1:0] cx;
		logic signed [FLD_W-1:0] cy;
		logic signed [FLD_W-1:0] cz;
		logic        [IDX_W-1:0] end_a;
		logic        [IDX_W-1:0] end_b;
		logic                    last_pair;
	} bond_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] shortest;
		logic [LEN_W-1:0] longest;
		logic [LEN_W-1:0] average;
		logic [CNT_W-1:0] bonds;
	} bond_stats_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                    start      = 1'b0;
	logic                    operation  = OP_WRITE;
	logic        [IDX_W-1:0] node_index = '0;
	logic signed [FLD_W-1:0] coord_x    = '0;
	logic signed [FLD_W-1:0] coord_y    = '0;
	logic signed [FLD_W-1:0] coord_z    = '0;
	logic        [IDX_W-1:0] end_a      = '0;
	logic        [IDX_W-1:0] end_b      = '0;
	logic                    last_pair  = 1'b0;

	logic             busy;
	logic             done;
	logic [LEN_W-1:0] min_length;
	logic [LEN_W-1:0] max_length;
	logic [LEN_W-1:0] mean_length;
	logic [CNT_W-1:0] bond_count;

	bond_item_t  pending_items[$];
	bond_stats_t expected_stats[$];
	int          fail_count = 0;

	// predictor copy of node memory and running statistics
	logic signed [FLD_W-1:0] node_pos[NODE_COUNT][3];
	logic [LEN_W-1:0]        run_min = '1;
	logic [LEN_W-1:0]        run_max = '0;
	logic [36:0]             run_sum = '0;
	logic [CNT_W-1:0]        run_count = '0;

	// stimulus-side record of which nodes hold a position
	bit gen_written[NODE_COUNT];
	int gen_nodes[$];

	bond_length_statistics_unit #(
		.MAX_NODES (NODE_COUNT),
		.MAX_BONDS (BOND_LIMIT),
		.COORD_BITS(COORD_W)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.node_index (node_index),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.end_a      (end_a),
		.end_b      (end_b),
		.last_pair  (last_pair),
		.done       (done),
		.min_length (min_length),
		.max_length (max_length),
		.mean_length(mean_length),
		.bond_count (bond_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// truncated Euclidean distance between two stored nodes, an unsigned integer
	function automatic logic [LEN_W-1:0] bond_distance(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic signed [FLD_W:0] diff;
		longint unsigned mag, rem, root, probe;
		rem = 0;
		for (int k = 0; k < 3; k++) begin
			diff = node_pos[a][k] - node_pos[b][k];
			if (diff < 0)
				diff = -diff;
			mag = diff;
			rem += mag * mag;
		end
		// bitwise integer square root, truncating
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe >>= 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem  -= root + probe;
				root  = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root[LEN_W-1:0];
	endfunction

	// apply one accepted item to the predictor, queue a result on a last bond
	function automatic void track_item(input bond_item_t it);
		logic [LEN_W-1:0] bond_len;
		bond_stats_t      r;
		if (it.operation == OP_WRITE) begin
			node_pos[it.node_index][0] = it.cx;
			node_pos[it.node_index][1] = it.cy;
			node_pos[it.node_index][2] = it.cz;
			return;
		end
		bond_len = bond_distance(it.end_a, it.end_b);
		if (run_count < BOND_LIMIT) begin
			if (bond_len < run_min)
				run_min = bond_len;
			if (bond_len > run_max)
				run_max = bond_len;
			run_sum   += bond_len;
			run_count += 1;
		end
		if (it.last_pair) begin
			r.shortest = run_min;
			r.longest  = run_max;
			r.average  = (run_count != 0) ? LEN_W'(run_sum / run_count) : '0;
			r.bonds    = run_count;
			expected_stats.push_back(r);
			run_min   = '1;
			run_max   = '0;
			run_sum   = '0;
			run_count = '0;
		end
	endfunction

	function automatic logic signed [FLD_W-1:0] pick_coord();
		int v;
		case ($urandom_range(0, 5))
			0: return {1'b1, {(FLD_W-1){1'b0}}};
			1: return {1'b0, {(FLD_W-1){1'b1}}};
			2, 3: begin
				v = int'($urandom_range(0, 8191)) - 4096;
				return v[FLD_W-1:0];
			end
			default: return FLD_W'($urandom());
		endcase
	endfunction

	// position write; bond fields carry noise
	task automatic push_write(input int idx, input logic signed [FLD_W-1:0] x,
			input logic signed [FLD_W-1:0] y, input logic signed [FLD_W-1:0] z);
		bond_item_t it;
		it.operation  = OP_WRITE;
		it.node_index = IDX_W'(idx);
		it.cx         = x;
		it.cy         = y;
		it.cz         = z;
		it.end_a      = IDX_W'($urandom());
		it.end_b      = IDX_W'($urandom());
		it.last_pair  = 1'($urandom());
		pending_items.push_back(it);
		if (!gen_written[idx]) begin
			gen_written[idx] = 1'b1;
			gen_nodes.push_back(idx);
		end
	endtask

	// bond measure; position fields carry noise
	task automatic push_measure(input int a, input int b, input bit last);
		bond_item_t it;
		it.operation  = OP_MEASURE;
		it.node_index = IDX_W'($urandom());
		it.cx         = FLD_W'($urandom());
		it.cy         = FLD_W'($urandom());
		it.cz         = FLD_W'($urandom());
		it.end_a      = IDX_W'(a);
		it.end_b      = IDX_W'(b);
		it.last_pair  = last;
		pending_items.push_back(it);
	endtask

	function automatic int any_written();
		return gen_nodes[$urandom_range(0, gen_nodes.size() - 1)];
	endfunction

	// driver: one item per start/!busy handshake, random gaps between items
	bond_item_t cur_item;
	int         gap_left  = 0;
	int         calm_left = 0;

	always @(posedge clk) begin
		int roll;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			if (start)
				track_item(cur_item);
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				operation  <= cur_item.operation;
				node_index <= cur_item.node_index;
				coord_x    <= cur_item.cx;
				coord_y    <= cur_item.cy;
				coord_z    <= cur_item.cz;
				end_a      <= cur_item.end_a;
				end_b      <= cur_item.end_b;
				last_pair  <= cur_item.last_pair;
				start      <= 1'b1;
				// mostly short gaps, a few long ones, now and then a run with none
				if (calm_left > 0) begin
					calm_left = calm_left - 1;
					gap_left  = 0;
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 3)
						calm_left = $urandom_range(20, 60);
					if (roll < 45)
						gap_left = 0;
					else if (roll < 85)
						gap_left = $urandom_range(1, 3);
					else if (roll < 96)
						gap_left = $urandom_range(4, 12);
					else
						gap_left = $urandom_range(20, 70);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every done strobe must match the oldest expected statistics
	always @(posedge clk) begin
		bond_stats_t want;
		if (arst_n && done) begin
			if (expected_stats.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected result min %0d max %0d mean %0d count %0d",
						$realtime, min_length, max_length, mean_length, bond_count);
			end else begin
				want = expected_stats.pop_front();
				if (min_length !== want.shortest || max_length !== want.longest ||
						mean_length !== want.average || bond_count !== want.bonds) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: stats mismatch, expected min %0d max %0d mean %0d count %0d",
							$realtime, want.shortest, want.longest, want.average, want.bonds);
						$display("    got min %0d max %0d mean %0d count %0d",
							min_length, max_length, mean_length, bond_count);
					end
				end
			end
		end
	end

	initial begin
		#30_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int a;
		int b;
		int idx;

		// directed: extreme positions, distances of zero and maximum, single-bond sets
		push_write(0, {1'b1, 23'd0}, {1'b1, 23'd0}, {1'b1, 23'd0});
		push_write(1023, {1'b0, {23{1'b1}}}, {1'b0, {23{1'b1}}}, {1'b0, {23{1'b1}}});
		push_write(512, 24'sd0, 24'sd0, 24'sd0);
		push_write(341, 24'sd256, -24'sd256, 24'sd1);
		push_write(682, {1'b0, {23{1'b1}}}, {1'b1, 23'd0}, 24'sd0);
		push_measure(0, 1023, 1'b0);
		push_measure(1023, 0, 1'b0);
		push_measure(0, 0, 1'b1);
		push_measure(341, 682, 1'b1);
		push_measure(512, 512, 1'b1);
		// overwrite a node, then measure against the new position
		push_write(0, 24'sd1, 24'sd1, 24'sd1);
		push_measure(0, 512, 1'b0);
		push_measure(682, 1023, 1'b0);
		push_measure(1023, 341, 1'b1);
		push_write(1023, -24'sd3, 24'sd4, 24'sd0);
		push_measure(1023, 512, 1'b1);

		// random: writes spread over the memory, measures on written nodes only
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (gen_nodes.size() < 8 || $urandom_range(0, 99) < 30) begin
				idx = ($urandom_range(0, 4) == 0) ? any_written() : $urandom_range(0, 1023);
				push_write(idx, pick_coord(), pick_coord(), pick_coord());
			end else begin
				a = any_written();
				b = ($urandom_range(0, 9) == 0) ? a : any_written();
				push_measure(a, b, $urandom_range(0, 5) == 0);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || start || expected_stats.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (fail_count == 0 && expected_stats.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
